// File: hw/rtl/tsega_pkg.sv
// Shared types and constants for the three-state edit graph aligner.
package tsega_pkg;
  localparam int CW = 11;
  localparam logic [CW-1:0] COST_INF = '1;

  localparam logic [1:0] CMD_LOAD_ORIG = 2'd0;
  localparam logic [1:0] CMD_LOAD_TGT  = 2'd1;
  localparam logic [1:0] CMD_RUN       = 2'd2;
  localparam logic [1:0] CMD_UNUSED    = 2'd3;

  localparam logic [1:0] OP_DEL  = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_NXT  = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [1:0] TO_STOP = 2'd0;
  localparam logic [1:0] TO_DEL  = 2'd1;
  localparam logic [1:0] TO_INS  = 2'd2;
  localparam logic [1:0] TO_NXT  = 2'd3;

  localparam logic [1:0] REG_FROM_DEL = 2'd0;
  localparam logic [1:0] REG_FROM_INS = 2'd1;
  localparam logic [1:0] REG_FROM_NXT = 2'd2;

  typedef struct packed {
    logic load_orig;
    logic load_tgt;
    logic fill_start;
    logic fill_wr;
    logic trace_start;
    logic trace_diag;
    logic trace_left;
    logic trace_emit;
    logic clear;
  } ctl_cmd_t;

  typedef struct packed {
    logic empty;
    logic fill_done;
    logic trace_done;
  } dp_stat_t;

  function automatic logic [CW-1:0] sadd(input logic [CW-1:0] a, input logic [3:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {{(CW-3){1'b0}}, b};
    if (a == COST_INF || s >= {1'b0, COST_INF}) return COST_INF;
    return s[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] min2(input logic [CW-1:0] a, input logic [CW-1:0] b);
    return (b < a) ? b : a;
  endfunction

  function automatic logic [3:0] nib(input logic [15:0] r, input logic [1:0] to);
    return r[{to, 2'b00} +: 4];
  endfunction
endpackage

// File: hw/rtl/tsega_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module tsega_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/tsega_ctrl.sv
// Sequencer for loading, graph fill and traceback.
module tsega_ctrl import tsega_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] cmd,
  output logic       busy,
  input  dp_stat_t   stat,
  output ctl_cmd_t   ctl
);
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_FRD    = 9'b000000010,
    S_FWR    = 9'b000000100,
    S_TSTART = 9'b000001000,
    S_TUP    = 9'b000010000,
    S_TDIAG  = 9'b000100000,
    S_TLEFT  = 9'b001000000,
    S_TEMIT  = 9'b010000000,
    S_CLEAR  = 9'b100000000
  } state_t;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load_orig = (cmd == CMD_LOAD_ORIG);
          ctl.load_tgt  = (cmd == CMD_LOAD_TGT);
          if (cmd == CMD_RUN) begin
            if (stat.empty) state_nxt = S_IDLE;
            else begin
              ctl.fill_start = 1'b1;
              state_nxt = S_FRD;
            end
          end
        end
      end
      S_FRD: begin
        state_nxt = S_FWR;
      end
      S_FWR: begin
        ctl.fill_wr = 1'b1;
        state_nxt = stat.fill_done ? S_TSTART : S_FRD;
      end
      S_TSTART: begin
        ctl.trace_start = 1'b1;
        state_nxt = S_TUP;
      end
      S_TUP: begin
        state_nxt = S_TDIAG;
      end
      S_TDIAG: begin
        ctl.trace_diag = 1'b1;
        state_nxt = S_TLEFT;
      end
      S_TLEFT: begin
        ctl.trace_left = 1'b1;
        state_nxt = S_TEMIT;
      end
      S_TEMIT: begin
        ctl.trace_emit = 1'b1;
        state_nxt = stat.trace_done ? S_CLEAR : S_TUP;
      end
      S_CLEAR: begin
        ctl.clear = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);
endmodule

// File: hw/rtl/tsega_dp.sv
// Datapath: string stores, cell cost memory, fill and traceback arithmetic.
module tsega_dp import tsega_pkg::*; #(
  parameter int MAX_LEN = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  ctl_cmd_t     ctl,
  output dp_stat_t     stat,
  input  logic [7:0]   in_data_byte,
  input  logic [15:0]  rd_r,
  input  logic [15:0]  ri_r,
  input  logic [15:0]  rn_r,
  output logic         out_valid,
  output logic [1:0]   out_op,
  output logic [7:0]   out_op_byte,
  output logic         out_last
);
  localparam int IW = $clog2(MAX_LEN + 1);
  localparam int SW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int GRID = (MAX_LEN + 1) * (MAX_LEN + 1);
  localparam int GW = $clog2(GRID);

  logic [IW-1:0] ocnt_r, tcnt_r;
  logic [IW-1:0] x_r, y_r;
  logic [GW-1:0] c_r;
  logic [1:0] prev_r;
  logic [CW-1:0] ldel_r, lnxt_r, up_ins_r, diag_nxt_r;
  logic [GW-1:0] w;
  logic load_o, load_t;
  logic [SW-1:0] xi, yi;
  logic [7:0] ob, tb;
  logic eq;
  logic mem_we;
  logic [GW-1:0] raddr;
  logic [3*CW-1:0] wdata, rdata;
  logic [CW-1:0] ed, ei, en, nd, ni, nn;
  logic [1:0] top;
  logic [CW-1:0] tc, tv;
  logic [IW-1:0] step_x, step_y;
  logic trace_end;

  assign load_o = ctl.load_orig && (ocnt_r < IW'(MAX_LEN));
  assign load_t = ctl.load_tgt && (tcnt_r < IW'(MAX_LEN));
  assign w = GW'(ocnt_r) + GW'(1);

  // Bytes for the current cell; the string stores read them through a registered port.
  assign xi = (x_r == '0) ? '0 : SW'(x_r - IW'(1));
  assign yi = (y_r == '0) ? '0 : SW'(y_r - IW'(1));

  tsega_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_orig (
    .clk(clk), .we(load_o), .waddr(ocnt_r[SW-1:0]), .wdata(in_data_byte),
    .raddr(xi), .rdata(ob)
  );
  tsega_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_tgt (
    .clk(clk), .we(load_t), .waddr(tcnt_r[SW-1:0]), .wdata(in_data_byte),
    .raddr(yi), .rdata(tb)
  );

  assign eq = (x_r != '0) && (y_r != '0) && (ob == tb);

  // Cost memory: one read port, cells hold {del, ins, nxt}.
  tsega_ram #(.WIDTH(3*CW), .DEPTH(GRID)) u_cost (
    .clk(clk), .we(mem_we), .waddr(c_r), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Fill: ins comes from the cell above, del from the cell to the left and nxt
  // from the cell above the left one, read while the previous cell was filled.
  always_comb begin
    ed = (x_r == '0) ? ((y_r == '0) ? '0 : COST_INF) : ldel_r;
    ei = (y_r == '0) ? ((x_r == '0) ? '0 : COST_INF) : rdata[2*CW-1:CW];
    if (x_r == '0) en = (y_r == '0) ? '0 : COST_INF;
    else if (y_r == '0) en = COST_INF;
    else en = eq ? lnxt_r : COST_INF;
    nd = min2(min2(sadd(ed, nib(rd_r, TO_DEL)), sadd(ei, nib(ri_r, TO_DEL))),
              sadd(en, nib(rn_r, TO_DEL)));
    ni = min2(min2(sadd(ei, nib(ri_r, TO_INS)), sadd(ed, nib(rd_r, TO_INS))),
              sadd(en, nib(rn_r, TO_INS)));
    nn = min2(min2(sadd(en, nib(rn_r, TO_NXT)), sadd(ed, nib(rd_r, TO_NXT))),
              sadd(ei, nib(ri_r, TO_NXT)));
  end

  // Traceback choice; the left cell's del cost is on the memory output.
  always_comb begin
    top = OP_NONE;
    tc = COST_INF;
    if (eq) begin
      top = OP_NXT;
      tc = sadd(diag_nxt_r, nib(rn_r, prev_r));
    end
    tv = sadd(up_ins_r, nib(ri_r, prev_r));
    if (y_r != '0 && (x_r == '0 || tv < tc)) begin
      top = OP_INS;
      tc = tv;
    end
    tv = sadd(rdata[3*CW-1:2*CW], nib(rd_r, prev_r));
    if (x_r != '0 && (y_r == '0 || tv < tc)) begin
      top = OP_DEL;
      tc = tv;
    end
    if (top == OP_NONE) top = OP_DEL;
  end

  always_comb begin
    step_x = x_r;
    step_y = y_r;
    if (top != OP_INS) step_x = x_r - IW'(1);
    if (top != OP_DEL) step_y = y_r - IW'(1);
  end
  assign trace_end = (step_x == '0) && (step_y == '0);

  always_comb begin
    mem_we = ctl.fill_wr;
    wdata = {nd, ni, nn};
    raddr = (y_r != '0) ? c_r - w : '0;
    if (ctl.trace_diag) raddr = (x_r != '0 && y_r != '0) ? c_r - w - GW'(1) : '0;
    if (ctl.trace_left) raddr = (x_r != '0) ? c_r - GW'(1) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= '0; tcnt_r <= '0; x_r <= '0; y_r <= '0; c_r <= '0;
      prev_r <= TO_STOP; out_valid <= 1'b0;
      out_op <= OP_DEL; out_op_byte <= 8'd0; out_last <= 1'b0;
    end else begin
      out_valid <= ctl.trace_emit;
      if (load_o) ocnt_r <= ocnt_r + IW'(1);
      if (load_t) tcnt_r <= tcnt_r + IW'(1);
      if (ctl.fill_start) begin
        x_r <= '0; y_r <= '0; c_r <= '0;
      end
      if (ctl.fill_wr) begin
        c_r <= c_r + GW'(1);
        if (x_r == ocnt_r) begin
          x_r <= '0; y_r <= y_r + IW'(1);
        end else x_r <= x_r + IW'(1);
      end
      if (ctl.trace_start) begin
        x_r <= ocnt_r; y_r <= tcnt_r; c_r <= c_r - GW'(1);
        prev_r <= TO_STOP;
      end
      if (ctl.trace_emit) begin
        out_op <= top;
        out_last <= trace_end;
        prev_r <= top + 2'd1;
        x_r <= step_x;
        y_r <= step_y;
        case (top)
          OP_NXT: begin
            out_op_byte <= 8'd0; c_r <= c_r - w - GW'(1);
          end
          OP_INS: begin
            out_op_byte <= tb; c_r <= c_r - w;
          end
          default: begin
            out_op_byte <= ob; c_r <= c_r - GW'(1);
          end
        endcase
      end
      if (ctl.clear) begin
        ocnt_r <= '0; tcnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fill_wr) begin
      ldel_r <= nd;
      lnxt_r <= rdata[CW-1:0];
    end
    if (ctl.trace_diag) up_ins_r <= rdata[2*CW-1:CW];
    if (ctl.trace_left) diag_nxt_r <= rdata[CW-1:0];
  end

  assign stat.empty = (ocnt_r == '0) && (tcnt_r == '0);
  assign stat.fill_done = (x_r == ocnt_r) && (y_r == tcnt_r);
  assign stat.trace_done = trace_end;
endmodule

// File: hw/rtl/three_state_edit_graph_align.sv
// Top level of the three-state edit graph aligner; one request is taken at a time.
// A run holds busy through the fill (one read and one write of the cost memory per cell),
// the setup state, the traceback states of each op (three reads of the single read port)
// and the clearing state.
// Each op is shown for one cycle on out_valid, in the cycle after it is chosen; no stall.
// Synchronous active-low reset clears counts and state and restores the cost registers.
module three_state_edit_graph_align import tsega_pkg::*; #(
  parameter int MAX_LEN = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  output logic [1:0]  out_op,
  output logic [7:0]  out_op_byte,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [15:0] rd_r, ri_r, rn_r;
  ctl_cmd_t ctl;
  dp_stat_t stat;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 16'h4313; ri_r <= 16'h3122; rn_r <= 16'h1321;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_FROM_DEL: rd_r <= pwdata[15:0];
        REG_FROM_INS: ri_r <= pwdata[15:0];
        REG_FROM_NXT: rn_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[3:2])
      REG_FROM_DEL: prdata = {16'd0, rd_r};
      REG_FROM_INS: prdata = {16'd0, ri_r};
      REG_FROM_NXT: prdata = {16'd0, rn_r};
      default: prdata = '0;
    endcase
  end

  tsega_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .cmd(in_cmd), .busy(busy),
    .stat(stat), .ctl(ctl)
  );

  tsega_dp #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .stat(stat), .in_data_byte(in_data_byte),
    .rd_r(rd_r), .ri_r(ri_r), .rn_r(rn_r), .out_valid(out_valid), .out_op(out_op),
    .out_op_byte(out_op_byte), .out_last(out_last)
  );

`ifndef SYNTHESIS
  a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !out_valid) else $error("result while idle");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid) else $error("result after last");
  a_op_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_op != OP_NONE) else $error("bad op code");
`endif
endmodule
